// ===== rtl/core/lfu_pkg.sv =====
package lfu_pkg;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] count;
    logic [63:0] last;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/lfu_ram.sv =====
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lfu_cache_replace.sv =====
// lfu_cache_replace: key/value cache with least-frequently-used replacement,
// ties broken by least recently used.
// input stream: s_tdata = {value, key}, s_tuser = action (0 get, 1 put).
// output stream: m_tdata = {evicted_key, read_value}, m_tuser = {evicted, hit}.
// one result item per input item.
// entries live in a single-port-write, registered-read memory; each item
// walks every entry once (one read a cycle) to find the key, the eviction
// victim and the lowest free slot, then writes the entry back in S_WB.
// a new item is taken in the cycle after the result is registered.
// the result register holds its item while m_tready is low; a further item
// can be accepted and scanned meanwhile, and waits at write-back.
// cfg_we/cfg_data write cache_limit (values above ENTRIES act as ENTRIES);
// write it only while the block is idle.
// reset (rst, synchronous) clears all valid bits, occupancy, the access
// clock and sets cache_limit to 16; no clearing pass is needed.
module lfu_cache_replace #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,      // cache_limit
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,       // key[31:0], value[63:32]
  input  logic        s_tuser,       // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,       // read_value[31:0], evicted_key[63:32]
  output logic [1:0]  m_tuser        // hit[0], evicted[1]
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int CW = (OW > 5) ? OW : 5;
  localparam logic [IW:0]   LAST_CNT = (IW + 1)'(ENTRIES);
  localparam logic [CW-1:0] ENT_C    = CW'(ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WB} state_t;

  state_t state;
  logic [4:0]          cache_limit;
  logic [ENTRIES-1:0]  valid;
  logic [ENTRIES-1:0]  valid_next;
  logic [OW-1:0]       occupancy;
  logic [63:0]         access_clock;

  logic                act;
  logic [31:0]         key_r;
  logic [31:0]         val_r;

  logic [IW:0]         rd_cnt;
  logic                pend;
  logic [IW-1:0]       pend_idx;

  logic                found;
  logic [IW-1:0]       found_idx;
  logic [31:0]         found_val;
  logic [31:0]         found_cnt;
  logic                vic_ok;
  logic [IW-1:0]       vic_idx;
  logic [31:0]         vic_cnt;
  logic [63:0]         vic_last;
  logic [31:0]         vic_key;
  logic                free_ok;
  logic [IW-1:0]       free_idx;

  lfu_pkg::entry_t     rd_entry;
  lfu_pkg::entry_t     wr_entry;
  logic [lfu_pkg::ENTRY_W-1:0] rd_raw;
  logic                we;
  logic [IW-1:0]       waddr;

  logic [CW-1:0]       lim_ext;
  logic [CW-1:0]       lim_eff;
  logic                out_free;
  logic                do_evict;
  logic                do_ins;
  logic [IW-1:0]       ins_idx;
  logic                take;
  logic                better;
  logic                vld_rd;

  lfu_ram #(.WIDTH(lfu_pkg::ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wr_entry),
    .raddr(rd_cnt[IW-1:0]),
    .rdata(rd_raw)
  );

  assign rd_entry = lfu_pkg::entry_t'(rd_raw);
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign lim_ext  = CW'(cache_limit);
  assign lim_eff  = (lim_ext > ENT_C) ? ENT_C : lim_ext;
  assign vld_rd   = valid[pend_idx];

  always_comb begin
    better = !vic_ok || rd_entry.count < vic_cnt ||
             (rd_entry.count == vic_cnt && rd_entry.last < vic_last);
    // put miss with room allowed: evict when full, then fill lowest free slot
    do_evict = (act == lfu_pkg::ACT_PUT) && (lim_eff != '0) && !found &&
               (CW'(occupancy) >= lim_eff) && vic_ok;
    do_ins   = (act == lfu_pkg::ACT_PUT) && (lim_eff != '0) && !found &&
               (do_evict || free_ok);
    ins_idx  = (do_evict && (!free_ok || vic_idx < free_idx)) ? vic_idx : free_idx;
    take     = (state == S_WB) && out_free;

    valid_next = valid;
    if (do_evict) begin
      valid_next[vic_idx] = 1'b0;
    end
    valid_next[ins_idx] = 1'b1;

    we       = 1'b0;
    waddr    = found_idx;
    wr_entry.key   = key_r;
    wr_entry.value = found_val;
    wr_entry.count = (found_cnt == lfu_pkg::COUNT_MAX) ? found_cnt : found_cnt + 32'd1;
    wr_entry.last  = access_clock;
    if (take) begin
      if (found && (act == lfu_pkg::ACT_GET || lim_eff != '0)) begin
        we = 1'b1;
        if (act == lfu_pkg::ACT_PUT) begin
          wr_entry.value = val_r;
        end
      end else if (do_ins) begin
        we             = 1'b1;
        waddr          = ins_idx;
        wr_entry.value = val_r;
        wr_entry.count = 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cache_limit  <= 5'd16;
      valid        <= '0;
      occupancy    <= '0;
      access_clock <= '0;
      m_tvalid     <= 1'b0;
      pend         <= 1'b0;
      rd_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        cache_limit <= cfg_data;
      end
      if (m_tvalid && m_tready && !take) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act     <= s_tuser;
            key_r   <= s_tdata[31:0];
            val_r   <= s_tdata[63:32];
            rd_cnt  <= '0;
            pend    <= 1'b0;
            found   <= 1'b0;
            vic_ok  <= 1'b0;
            free_ok <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_cnt != LAST_CNT) begin
            pend     <= 1'b1;
            pend_idx <= rd_cnt[IW-1:0];
            rd_cnt   <= rd_cnt + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (vld_rd && !found && rd_entry.key == key_r) begin
              found     <= 1'b1;
              found_idx <= pend_idx;
              found_val <= rd_entry.value;
              found_cnt <= rd_entry.count;
            end
            if (vld_rd && better) begin
              vic_ok   <= 1'b1;
              vic_idx  <= pend_idx;
              vic_cnt  <= rd_entry.count;
              vic_last <= rd_entry.last;
              vic_key  <= rd_entry.key;
            end
            if (!vld_rd && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= pend_idx;
            end
          end
          if (rd_cnt == LAST_CNT && !pend) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (out_free) begin
            m_tvalid       <= 1'b1;
            m_tuser[0]     <= found;
            m_tuser[1]     <= do_evict;
            m_tdata[63:32] <= do_evict ? vic_key : 32'd0;
            if (act == lfu_pkg::ACT_GET) begin
              m_tdata[31:0] <= found ? found_val : lfu_pkg::MISS_VALUE;
            end else begin
              m_tdata[31:0] <= 32'd0;
            end
            if (we) begin
              access_clock <= access_clock + 64'd1;
            end
            if (do_ins) begin
              valid <= valid_next;
              if (!do_evict) begin
                occupancy <= occupancy + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    OW'(ENTRIES) >= occupancy) else $error("occupancy above capacity");

  a_occ_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(occupancy)) else $error("occupancy out of step with valid bits");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    take && do_evict |=> occupancy == $past(occupancy))
    else $error("eviction changed occupancy");

  a_evict_needs_victim: assert property (@(posedge clk) disable iff (rst)
    take && do_evict |-> valid[vic_idx] && !found)
    else $error("eviction of an invalid entry");

endmodule
